// ===== src/ymodem_receiver_assert.svh =====
// Assertion macros used by the checker file ymr_checker.sv.
`ifndef YMODEM_RECEIVER_ASSERT_SVH
`define YMODEM_RECEIVER_ASSERT_SVH

`define YMR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define YMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/ymr_pkg.sv =====
// Shared types, constants and functions of the YMODEM receiver.
package ymr_pkg;

  localparam int SMALL_BLOCK    = 128;
  localparam int LARGE_BLOCK    = 1024;
  localparam int SIZE_FIELD_LEN = 16;
  localparam int CNT_W          = $clog2(LARGE_BLOCK + 1);
  localparam int SLEN_W         = $clog2(SIZE_FIELD_LEN + 1);
  localparam int QDEPTH         = 2;
  localparam int MAX_RES        = 4;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;
  localparam logic [7:0] CH_UA  = 8'h41;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_COMMIT = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  localparam logic [2:0] ST_RUN       = 3'd0;
  localparam logic [2:0] ST_DONE      = 3'd1;
  localparam logic [2:0] ST_SND_ABORT = 3'd2;
  localparam logic [2:0] ST_LOC_ABORT = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_OVERFLOW  = 3'd5;

  localparam logic REG_MAX_ERR = 1'b0;
  localparam logic REG_CAP     = 1'b1;

  typedef enum logic [2:0] {
    SZ_NAME  = 3'd0,
    SZ_START = 3'd1,
    SZ_ZERO  = 3'd2,
    SZ_HEX   = 3'd3,
    SZ_DEC   = 3'd4,
    SZ_END   = 3'd5,
    SZ_BAD   = 3'd6,
    SZ_EMPTY = 3'd7
  } size_mode_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] offset;
    logic [2:0]  status;
  } res_t;

  typedef struct packed {
    logic [2:0]              cnt;
    res_t [MAX_RES-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic        cap_we;
    logic [31:0] cap;
    logic [7:0]  max_errors;
  } cfg_t;

  function automatic bundle_t push(bundle_t b, logic [1:0] k, logic [7:0] v,
                                   logic [31:0] o, logic [2:0] s);
    bundle_t r;
    r = b;
    if (b.cnt < 3'(MAX_RES)) begin
      r.res[b.cnt[1:0]].kind   = k;
      r.res[b.cnt[1:0]].value  = v;
      r.res[b.cnt[1:0]].offset = o;
      r.res[b.cnt[1:0]].status = s;
      r.cnt = b.cnt + 3'd1;
    end
    return r;
  endfunction

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ===== src/ymr_front.sv =====
// Front end: accepts line bytes, runs the packet state machine and builds result bundles.
module ymr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  ymr_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  logic              in_op,
  input  logic [7:0]        in_byte,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push_valid,
  output ymr_pkg::bundle_t  push_data
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_CAN, PH_SEQ, PH_CSEQ, PH_DATA, PH_CRCH, PH_CRCL, PH_DONE
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [ymr_pkg::CNT_W-1:0]    byte_count_r, byte_count_nxt;
  logic                         large_r, large_nxt;
  logic [7:0]                   seq_r, seq_nxt;
  logic [7:0]                   exp_seq_r, exp_seq_nxt;
  logic                         hdr_seen_r, hdr_seen_nxt;
  logic [15:0]                  crc_r, crc_nxt;
  logic [7:0]                   rcrc_hi_r, rcrc_hi_nxt;
  logic [7:0]                   err_cnt_r, err_cnt_nxt;
  logic                         started_r, started_nxt;
  logic [31:0]                  wr_off_r, wr_off_nxt;
  logic [31:0]                  space_r, space_nxt;
  logic [31:0]                  size_r, size_nxt;
  ymr_pkg::size_mode_t          mode_r, mode_nxt;
  logic [ymr_pkg::SLEN_W-1:0]   slen_r, slen_nxt;
  logic                         seq_ok_r, seq_ok_nxt;

  logic                         fire;
  logic                         do_err;
  logic                         good;
  logic [7:0]                   ec_err;
  logic [ymr_pkg::CNT_W-1:0]    blk_len;
  logic [ymr_pkg::CNT_W-1:0]    cnt_inc;
  logic [31:0]                  hdr_size;
  logic [3:0]                   digit;
  ymr_pkg::bundle_t             bnd;

  assign in_ready = !q_full;
  assign fire     = in_valid && !q_full;
  assign blk_len  = large_r ? ymr_pkg::CNT_W'(ymr_pkg::LARGE_BLOCK)
                            : ymr_pkg::CNT_W'(ymr_pkg::SMALL_BLOCK);
  assign cnt_inc  = byte_count_r + 1'b1;
  assign push_valid = fire && (bnd.cnt != 3'd0);
  assign push_data  = bnd;

  always_comb begin
    phase_nxt = phase_r; byte_count_nxt = byte_count_r; large_nxt = large_r;
    seq_nxt = seq_r; exp_seq_nxt = exp_seq_r; hdr_seen_nxt = hdr_seen_r;
    crc_nxt = crc_r; rcrc_hi_nxt = rcrc_hi_r; err_cnt_nxt = err_cnt_r;
    started_nxt = started_r; wr_off_nxt = wr_off_r; space_nxt = space_r;
    size_nxt = size_r; mode_nxt = mode_r; slen_nxt = slen_r; seq_ok_nxt = seq_ok_r;
    bnd = '0;
    do_err = 1'b0;
    good = 1'b0;
    hdr_size = '0;
    digit = '0;
    ec_err = '0;
    if (cfg.cap_we) space_nxt = cfg.cap;
    if (fire && phase_r != PH_DONE) begin
      if (in_op) begin
        do_err = 1'b1;
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            if (in_byte == ymr_pkg::CH_SOH || in_byte == ymr_pkg::CH_STX) begin
              large_nxt = (in_byte == ymr_pkg::CH_STX);
              byte_count_nxt = '0; crc_nxt = '0; size_nxt = '0;
              mode_nxt = ymr_pkg::SZ_NAME; slen_nxt = '0; phase_nxt = PH_SEQ;
            end else if (in_byte == ymr_pkg::CH_EOT) begin
              err_cnt_nxt = '0; exp_seq_nxt = '0; hdr_seen_nxt = 1'b0;
              bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_ACK, '0, '0);
            end else if (in_byte == ymr_pkg::CH_CAN) begin
              phase_nxt = PH_CAN;
            end else if (in_byte == ymr_pkg::CH_UA || in_byte == ymr_pkg::CH_LA) begin
              bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
              bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
              bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_STATUS, '0, '0, ymr_pkg::ST_LOC_ABORT);
              phase_nxt = PH_DONE;
            end else begin
              do_err = 1'b1;
            end
          end
          PH_CAN: begin
            phase_nxt = PH_IDLE;
            if (in_byte == ymr_pkg::CH_CAN) begin
              err_cnt_nxt = '0;
              bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_ACK, '0, '0);
              bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_STATUS, '0, '0, ymr_pkg::ST_SND_ABORT);
              phase_nxt = PH_DONE;
            end else begin
              do_err = 1'b1;
            end
          end
          PH_SEQ: begin
            seq_nxt = in_byte; phase_nxt = PH_CSEQ;
          end
          PH_CSEQ: begin
            seq_ok_nxt = (seq_r == ~in_byte); phase_nxt = PH_DATA;
          end
          PH_DATA: begin
            crc_nxt = ymr_pkg::crc_update(crc_r, in_byte);
            if (hdr_seen_r) begin
              if (32'(byte_count_r) < space_r)
                bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_DATA, in_byte,
                                    wr_off_r + 32'(byte_count_r), '0);
            end else if (mode_r == ymr_pkg::SZ_NAME) begin
              if (in_byte == 8'h00)
                mode_nxt = (byte_count_r == '0) ? ymr_pkg::SZ_EMPTY : ymr_pkg::SZ_START;
            end else if (mode_r >= ymr_pkg::SZ_START && mode_r <= ymr_pkg::SZ_DEC) begin
              if (in_byte == 8'h00 || in_byte == 8'h20) begin
                mode_nxt = ymr_pkg::SZ_END;
              end else begin
                digit = in_byte[3:0];
                if (mode_r == ymr_pkg::SZ_START && in_byte == "0") begin
                  mode_nxt = ymr_pkg::SZ_ZERO;
                end else if (mode_r == ymr_pkg::SZ_ZERO && (in_byte == "x" || in_byte == "X")) begin
                  mode_nxt = ymr_pkg::SZ_HEX;
                end else if (mode_r == ymr_pkg::SZ_HEX) begin
                  if (in_byte >= "0" && in_byte <= "9")
                    size_nxt = {size_r[27:0], 4'h0} + 32'(digit);
                  else if ((in_byte >= "a" && in_byte <= "f") ||
                           (in_byte >= "A" && in_byte <= "F"))
                    size_nxt = {size_r[27:0], 4'h0} + 32'(digit) + 32'd9;
                  else
                    mode_nxt = ymr_pkg::SZ_BAD;
                end else begin
                  mode_nxt = ymr_pkg::SZ_DEC;
                  if (in_byte >= "0" && in_byte <= "9")
                    size_nxt = {size_r[28:0], 3'b0} + {size_r[30:0], 1'b0} + 32'(digit);
                  else if ((in_byte == "k" || in_byte == "K") && slen_r != '0)
                    size_nxt = {size_r[21:0], 10'b0};
                  else if ((in_byte == "m" || in_byte == "M") && slen_r != '0)
                    size_nxt = {size_r[11:0], 20'b0};
                  else
                    mode_nxt = ymr_pkg::SZ_BAD;
                end
                slen_nxt = slen_r + 1'b1;
                if (mode_nxt >= ymr_pkg::SZ_ZERO && mode_nxt <= ymr_pkg::SZ_DEC &&
                    32'(slen_nxt) >= 32'(ymr_pkg::SIZE_FIELD_LEN))
                  mode_nxt = ymr_pkg::SZ_END;
              end
            end
            byte_count_nxt = cnt_inc;
            if (cnt_inc >= blk_len) phase_nxt = PH_CRCH;
          end
          PH_CRCH: begin
            rcrc_hi_nxt = in_byte; phase_nxt = PH_CRCL;
          end
          PH_CRCL: begin
            if (seq_ok_r && {rcrc_hi_r, in_byte} == crc_r) good = 1'b1;
            else do_err = 1'b1;
          end
          PH_DONE: phase_nxt = PH_DONE;
          default: phase_nxt = PH_IDLE;
        endcase
      end
      if (good) begin
        phase_nxt = PH_IDLE;
        err_cnt_nxt = '0;
        if (seq_r != exp_seq_r) begin
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_NAK, '0, '0);
        end else if (!hdr_seen_r) begin
          hdr_size = (mode_r == ymr_pkg::SZ_BAD || mode_r == ymr_pkg::SZ_NAME) ? '0 : size_r;
          if (mode_r == ymr_pkg::SZ_EMPTY) begin
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_ACK, '0, '0);
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_STATUS, '0, '0, ymr_pkg::ST_DONE);
            phase_nxt = PH_DONE;
          end else if (hdr_size > space_r) begin
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_STATUS, '0, '0, ymr_pkg::ST_TOO_LARGE);
            phase_nxt = PH_DONE;
          end else begin
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_ACK, '0, '0);
            bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_C, '0, '0);
            hdr_seen_nxt = 1'b1;
            exp_seq_nxt = exp_seq_r + 8'd1;
            started_nxt = 1'b1;
          end
        end else if (space_r < 32'(blk_len)) begin
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_STATUS, '0, '0, ymr_pkg::ST_OVERFLOW);
          phase_nxt = PH_DONE;
        end else begin
          wr_off_nxt = wr_off_r + 32'(blk_len);
          space_nxt = space_r - 32'(blk_len);
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_COMMIT, '0, wr_off_r + 32'(blk_len), '0);
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_ACK, '0, '0);
          exp_seq_nxt = exp_seq_r + 8'd1;
          started_nxt = 1'b1;
        end
      end
      if (do_err) begin
        phase_nxt = PH_IDLE;
        ec_err = (started_r && err_cnt_r != 8'hFF) ? err_cnt_r + 8'd1 : err_cnt_r;
        err_cnt_nxt = ec_err;
        if (ec_err > cfg.max_errors) begin
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_CAN, '0, '0);
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_STATUS, '0, '0, ymr_pkg::ST_LOC_ABORT);
          phase_nxt = PH_DONE;
        end else begin
          bnd = ymr_pkg::push(bnd, ymr_pkg::KIND_REPLY, ymr_pkg::CH_C, '0, '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; byte_count_r <= '0; large_r <= 1'b0; seq_r <= '0;
      exp_seq_r <= '0; hdr_seen_r <= 1'b0; crc_r <= '0; rcrc_hi_r <= '0;
      err_cnt_r <= '0; started_r <= 1'b0; wr_off_r <= '0; space_r <= '0;
      size_r <= '0; mode_r <= ymr_pkg::SZ_NAME; slen_r <= '0; seq_ok_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; byte_count_r <= byte_count_nxt; large_r <= large_nxt;
      seq_r <= seq_nxt; exp_seq_r <= exp_seq_nxt; hdr_seen_r <= hdr_seen_nxt;
      crc_r <= crc_nxt; rcrc_hi_r <= rcrc_hi_nxt; err_cnt_r <= err_cnt_nxt;
      started_r <= started_nxt; wr_off_r <= wr_off_nxt; space_r <= space_nxt;
      size_r <= size_nxt; mode_r <= mode_nxt; slen_r <= slen_nxt; seq_ok_r <= seq_ok_nxt;
    end
  end

endmodule

// ===== src/ymr_queue.sv =====
// Short queue of result bundles between the front and back ends.
module ymr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  ymr_pkg::bundle_t  wr_data,
  input  logic              rd_en,
  output logic              full,
  output logic              rd_valid,
  output ymr_pkg::bundle_t  rd_data
);

  localparam int PW = $clog2(ymr_pkg::QDEPTH);

  ymr_pkg::bundle_t [ymr_pkg::QDEPTH-1:0] mem_r;
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;

  assign full     = (cnt_r == (PW+1)'(ymr_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd_en ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== src/ymr_back.sv =====
// Back end: holds one bundle and sends its results one per transaction.
module ymr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  ymr_pkg::bundle_t  q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ymr_pkg::res_t     out_res,
  output logic              out_last
);

  ymr_pkg::bundle_t cur_r, cur_nxt;
  logic             cur_v_r, cur_v_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             fire;

  assign out_valid = cur_v_r;
  assign out_res   = cur_r.res[idx_r];
  assign out_last  = ({1'b0, idx_r} == cur_r.cnt - 3'd1);
  assign fire      = cur_v_r && out_ready;
  assign q_pop     = q_valid && (!cur_v_r || (fire && out_last));

  always_comb begin
    cur_nxt = cur_r;
    cur_v_nxt = cur_v_r;
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = idx_r + 2'd1;
      if (out_last) cur_v_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_nxt = q_data;
      cur_v_nxt = 1'b1;
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (!rst_n) begin
      cur_v_r <= 1'b0; idx_r <= '0;
    end else begin
      cur_v_r <= cur_v_nxt; idx_r <= idx_nxt;
    end
  end

endmodule

// ===== src/ymodem_receiver.sv =====
// Each result passes through the bundle queue and the back end's bundle register.
// Throughput: one input transaction per cycle while the queue is not full; results
// leave one per cycle while out_tready is high, buffered by a
// two-bundle queue. Synchronous active-low reset returns to waiting for a start
// byte with max_errors 5 and dest_capacity 0; configuration writes apply at once.
module ymodem_receiver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic        in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] value, [39:8] offset, [42:40] status, zeros
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]       max_err_r;
  logic [31:0]      cap_r;
  logic             wr;
  ymr_pkg::cfg_t    cfg;
  logic             q_full, push_v, q_valid, q_pop;
  ymr_pkg::bundle_t push_d, q_data;
  ymr_pkg::res_t    res;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg.cap_we = wr && (cfg_paddr[2] == ymr_pkg::REG_CAP);
  assign cfg.cap = cfg_pwdata;
  assign cfg.max_errors = max_err_r;
  assign cfg_prdata = (cfg_paddr[2] == ymr_pkg::REG_CAP) ? cap_r : {24'b0, max_err_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_err_r <= 8'd5; cap_r <= '0;
    end else if (wr) begin
      if (cfg_paddr[2] == ymr_pkg::REG_MAX_ERR) max_err_r <= cfg_pwdata[7:0];
      else cap_r <= cfg_pwdata;
    end
  end

  ymr_front u_front (
    .clk, .rst_n, .cfg,
    .in_valid(in_tvalid), .in_op(in_tuser), .in_byte(in_tdata),
    .q_full, .in_ready(in_tready), .push_valid(push_v), .push_data(push_d)
  );

  ymr_queue u_queue (
    .clk, .rst_n, .wr_en(push_v), .wr_data(push_d), .rd_en(q_pop),
    .full(q_full), .rd_valid(q_valid), .rd_data(q_data)
  );

  ymr_back u_back (
    .clk, .rst_n, .q_valid, .q_data, .q_pop,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res), .out_last(out_tlast)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {5'b0, res.status, res.offset, res.value};

endmodule

// ===== src/ymr_checker.sv =====
// Port-level assertion checker for the YMODEM receiver, bound to the top level.
`include "ymodem_receiver_assert.svh"
module ymr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_penable,
  input logic        cfg_pwrite,
  input logic [2:0]  cfg_paddr,
  input logic [31:0] cfg_pwdata,
  input logic [31:0] cfg_prdata,
  input logic        cfg_pready
);

  `YMR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `YMR_ASSERT_IMPLY(a_status_last, out_tvalid && out_tuser == ymr_pkg::KIND_STATUS, out_tlast)
  `YMR_ASSERT_IMPLY(a_status_only, out_tvalid && out_tuser != ymr_pkg::KIND_STATUS, out_tdata[42:40] == 3'd0)
  `YMR_ASSERT_IMPLY(a_reply_nooff, out_tvalid && out_tuser == ymr_pkg::KIND_REPLY, out_tdata[39:8] == 32'd0)

endmodule

bind ymodem_receiver ymr_checker u_ymr_checker (.*);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the YMODEM receiver: directed and random line traffic.
`timescale 1ns / 100ps

module testbench;
  import ymr_pkg::*;

  typedef enum logic [3:0] {
    RX_IDLE, RX_CAN, RX_SEQ, RX_CSEQ, RX_DATA, RX_CRCH, RX_CRCL, RX_DONE
  } rx_phase_t;

  typedef struct {
    rx_phase_t   phase;
    logic [10:0] cnt;
    bit          large_blk;
    logic [7:0]  seq;
    logic [7:0]  exp_seq;
    bit          hdr_seen;
    logic [15:0] crc;
    logic [15:0] rx_crc;
    logic [7:0]  errs;
    bit          started;
    logic [31:0] woff;
    logic [31:0] space;
    logic [31:0] fsize;
    size_mode_t  mode;
    int          slen;
    bit          seq_ok;
  } rx_state_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [31:0] offset;
    logic [2:0]  status;
    bit          last;
  } rx_result_t;

  localparam bit OP_BYTE = 1'b0;
  localparam bit OP_TIMEOUT = 1'b1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] rx_byte
  logic        in_tuser;   // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [7:0] value, [39:8] offset, [42:40] status, zeros
  logic [1:0]  out_tuser;  // [1:0] kind
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rx_state_t   rx;
  logic [7:0]  max_err_cfg;
  rx_result_t  expected_q[$];
  int          mismatches;
  int          items_in;
  int          results_seen;
  int          idle_cycles;
  int          hold_req;
  int          out_stall;
  bit          gaps_on;

  ymodem_receiver DUT (.*);

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    return c;
  endfunction

  function automatic void add_result(inout rx_result_t r[4], inout int n, input logic [1:0] k,
                                     input logic [7:0] v, input logic [31:0] o,
                                     input logic [2:0] st);
    if (n < 4) begin
      r[n].kind = k;
      r[n].value = v;
      r[n].offset = o;
      r[n].status = st;
      r[n].last = 1'b0;
      n++;
    end
  endfunction

  function automatic void end_session(inout rx_state_t s, inout rx_result_t r[4], inout int n,
                                      input logic [2:0] st, input bit cancel);
    if (cancel) begin
      add_result(r, n, KIND_REPLY, CH_CAN, 0, ST_RUN);
      add_result(r, n, KIND_REPLY, CH_CAN, 0, ST_RUN);
    end
    s.phase = RX_DONE;
    add_result(r, n, KIND_STATUS, 8'h00, 0, st);
  endfunction

  function automatic void line_error(inout rx_state_t s, inout rx_result_t r[4], inout int n);
    s.phase = RX_IDLE;
    if (s.started && s.errs < 8'hFF) s.errs++;
    if (s.errs > max_err_cfg) end_session(s, r, n, ST_LOC_ABORT, 1'b1);
    else add_result(r, n, KIND_REPLY, CH_C, 0, ST_RUN);
  endfunction

  function automatic void size_digit(inout rx_state_t s, input logic [7:0] b);
    if (b >= "0" && b <= "9") s.fsize = s.fsize * 10 + 32'(b - 8'h30);
    else if ((b == "k" || b == "K") && s.slen > 0) s.fsize = s.fsize << 10;
    else if ((b == "m" || b == "M") && s.slen > 0) s.fsize = s.fsize << 20;
    else begin
      s.mode = SZ_BAD;
      return;
    end
    s.mode = SZ_DEC;
  endfunction

  function automatic int rx_predict(inout rx_state_t s, input bit tmo, input logic [7:0] b,
                                    output rx_result_t r[4]);
    int n;
    logic [31:0] len;
    logic [31:0] sz;
    n = 0;
    len = s.large_blk ? LARGE_BLOCK : SMALL_BLOCK;
    if (s.phase == RX_DONE) return 0;
    if (tmo) line_error(s, r, n);
    else begin
      case (s.phase)
        RX_IDLE: begin
          if (b == CH_SOH || b == CH_STX) begin
            s.large_blk = (b == CH_STX);
            s.cnt = 0;
            s.crc = 0;
            s.fsize = 0;
            s.mode = SZ_NAME;
            s.slen = 0;
            s.phase = RX_SEQ;
          end else if (b == CH_EOT) begin
            s.errs = 0;
            s.exp_seq = 0;
            s.hdr_seen = 0;
            add_result(r, n, KIND_REPLY, CH_ACK, 0, ST_RUN);
          end else if (b == CH_CAN) s.phase = RX_CAN;
          else if (b == CH_UA || b == CH_LA) end_session(s, r, n, ST_LOC_ABORT, 1'b1);
          else line_error(s, r, n);
        end
        RX_CAN: begin
          s.phase = RX_IDLE;
          if (b == CH_CAN) begin
            s.errs = 0;
            add_result(r, n, KIND_REPLY, CH_ACK, 0, ST_RUN);
            end_session(s, r, n, ST_SND_ABORT, 1'b0);
          end else line_error(s, r, n);
        end
        RX_SEQ: begin
          s.seq = b;
          s.phase = RX_CSEQ;
        end
        RX_CSEQ: begin
          s.seq_ok = (s.seq == ~b);
          s.phase = RX_DATA;
        end
        RX_DATA: begin
          s.crc = crc16_step(s.crc, b);
          if (s.hdr_seen) begin
            if (32'(s.cnt) < s.space) add_result(r, n, KIND_DATA, b, s.woff + 32'(s.cnt), ST_RUN);
          end else if (s.mode == SZ_NAME) begin
            if (b == 0) s.mode = (s.cnt == 0) ? SZ_EMPTY : SZ_START;
          end else if (s.mode >= SZ_START && s.mode <= SZ_DEC) begin
            if (b == 8'h00 || b == 8'h20) s.mode = SZ_END;
            else begin
              case (s.mode)
                SZ_START: if (b == "0") s.mode = SZ_ZERO; else size_digit(s, b);
                SZ_ZERO: if (b == "x" || b == "X") s.mode = SZ_HEX; else size_digit(s, b);
                SZ_HEX: begin
                  if (b >= "0" && b <= "9") s.fsize = (s.fsize << 4) + 32'(b - 8'h30);
                  else if (b >= "a" && b <= "f") s.fsize = (s.fsize << 4) + 32'(b - 8'h57);
                  else if (b >= "A" && b <= "F") s.fsize = (s.fsize << 4) + 32'(b - 8'h37);
                  else s.mode = SZ_BAD;
                end
                default: size_digit(s, b);
              endcase
              s.slen++;
              if (s.mode >= SZ_ZERO && s.mode <= SZ_DEC && s.slen >= SIZE_FIELD_LEN)
                s.mode = SZ_END;
            end
          end
          s.cnt = s.cnt + 11'd1;
          if (32'(s.cnt) >= len) s.phase = RX_CRCH;
        end
        RX_CRCH: begin
          s.rx_crc = {b, 8'h00};
          s.phase = RX_CRCL;
        end
        RX_CRCL: begin
          s.rx_crc[7:0] = b;
          if (!(s.seq_ok && s.rx_crc == s.crc)) line_error(s, r, n);
          else begin
            s.phase = RX_IDLE;
            s.errs = 0;
            if (s.seq != s.exp_seq) add_result(r, n, KIND_REPLY, CH_NAK, 0, ST_RUN);
            else if (!s.hdr_seen) begin
              sz = (s.mode == SZ_BAD || s.mode == SZ_NAME) ? 32'd0 : s.fsize;
              if (s.mode == SZ_EMPTY) begin
                add_result(r, n, KIND_REPLY, CH_ACK, 0, ST_RUN);
                end_session(s, r, n, ST_DONE, 1'b0);
              end else if (sz > s.space) end_session(s, r, n, ST_TOO_LARGE, 1'b1);
              else begin
                add_result(r, n, KIND_REPLY, CH_ACK, 0, ST_RUN);
                add_result(r, n, KIND_REPLY, CH_C, 0, ST_RUN);
                s.hdr_seen = 1;
                s.exp_seq++;
                s.started = 1;
              end
            end else if (s.space < len) end_session(s, r, n, ST_OVERFLOW, 1'b1);
            else begin
              s.woff += len;
              s.space -= len;
              add_result(r, n, KIND_COMMIT, 8'h00, s.woff, ST_RUN);
              add_result(r, n, KIND_REPLY, CH_ACK, 0, ST_RUN);
              s.exp_seq++;
              s.started = 1;
            end
          end
        end
        default: s.phase = RX_IDLE;
      endcase
    end
    if (n > 0) r[n-1].last = 1'b1;
    return n;
  endfunction

  function automatic bit ends_session(bit tmo, logic [7:0] b);
    rx_state_t c;
    rx_result_t r[4];
    c = rx;
    void'(rx_predict(c, tmo, b, r));
    return c.phase == RX_DONE;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_line(bit tmo, logic [7:0] b, bit keep_alive = 1'b0);
    rx_result_t r[4];
    int n;
    if (keep_alive && rx.phase != RX_DONE) begin
      for (int t = 0; t < 8 && ends_session(tmo, b); t++) b = 8'($urandom);
      if (ends_session(tmo, b)) tmo = OP_TIMEOUT;
    end
    if (gaps_on && $urandom_range(3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= tmo;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_in++;
    n = rx_predict(rx, tmo, b, r);
    for (int i = 0; i < n; i++) expected_q.push_back(r[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_MAX_ERR) max_err_cfg = data[7:0];
    else rx.space = data;
  endtask

  function automatic void header_body(output logic [7:0] body[$]);
    int pick;
    body.delete();
    repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(8'h61, 8'h7A)));
    body.push_back(8'h00);
    pick = $urandom_range(5);
    case (pick)
      0: repeat ($urandom_range(1, 6)) body.push_back(8'($urandom_range(8'h30, 8'h39)));
      1: begin
        body.push_back("3");
        body.push_back($urandom_range(1) ? "k" : "K");
      end
      2: begin
        body.push_back("2");
        body.push_back($urandom_range(1) ? "M" : "m");
      end
      3: begin
        body.push_back("0");
        body.push_back($urandom_range(1) ? "x" : "X");
        body.push_back("A");
        body.push_back("f");
        body.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
      4: begin
        body.push_back("1");
        body.push_back(8'($urandom_range(8'h21, 8'h2F)));
      end
      default: repeat (20) body.push_back(8'($urandom_range(8'h31, 8'h39)));
    endcase
    body.push_back($urandom_range(1) ? 8'h20 : 8'h00);
  endfunction

  task automatic send_packet(bit large_blk, logic [7:0] seq, logic [7:0] body[$],
                             bit bad_crc = 0, bit bad_cmp = 0, bit keep_alive = 1);
    int len;
    logic [15:0] crc;
    logic [7:0] b;
    len = large_blk ? LARGE_BLOCK : SMALL_BLOCK;
    crc = 0;
    send_line(OP_BYTE, large_blk ? CH_STX : CH_SOH, keep_alive);
    send_line(OP_BYTE, seq, keep_alive);
    send_line(OP_BYTE, bad_cmp ? seq : ~seq, keep_alive);
    for (int i = 0; i < len; i++) begin
      b = (i < body.size()) ? body[i] : 8'($urandom);
      crc = crc16_step(crc, b);
      send_line(OP_BYTE, b, keep_alive);
    end
    if (bad_crc) crc ^= 16'(1 << $urandom_range(15));
    send_line(OP_BYTE, crc[15:8], keep_alive);
    send_line(OP_BYTE, crc[7:0], keep_alive);
  endtask

  task automatic send_good_packet(bit large_blk = 0);
    logic [7:0] body[$];
    if (!rx.hdr_seen) header_body(body);
    else body.delete();
    send_packet(large_blk, rx.exp_seq, body);
  endtask

  task automatic test_line_events();
    write_reg(REG_MAX_ERR, 32'd0);
    write_reg(REG_CAP, 32'd0);
    send_line(OP_TIMEOUT, 8'hFF);
    send_line(OP_TIMEOUT, 8'h00);
    send_line(OP_BYTE, 8'h00);
    send_line(OP_BYTE, 8'hFF);
    send_line(OP_BYTE, CH_EOT);
    send_line(OP_BYTE, CH_CAN);
    send_line(OP_BYTE, 8'h55);
    send_line(OP_BYTE, CH_C);
    send_line(OP_BYTE, CH_SOH);
    send_line(OP_BYTE, 8'h00);
    send_line(OP_TIMEOUT, 8'hAA);
    wait_drained();
  endtask

  task automatic test_header_and_data();
    logic [7:0] body[$];
    write_reg(REG_MAX_ERR, 32'd255);
    write_reg(REG_CAP, 32'hFFFF_FFFF);
    body = '{"f", "1", 8'h00, "1", "2", "k", 8'h20};
    send_packet(0, 8'h00, body);
    send_line(OP_TIMEOUT, 8'h00);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    hold_req = 300;
    send_good_packet();
    wait_drained();
  endtask

  task automatic random_traffic(int target);
    int start;
    int pick;
    start = items_in;
    while (items_in - start < target) begin
      pick = $urandom_range(99);
      if (pick < 15) send_line(OP_BYTE, CH_EOT, 1);
      else if (pick < 35) send_line(OP_TIMEOUT, 8'($urandom), 1);
      else if (pick < 60) send_line(OP_BYTE, 8'($urandom), 1);
      else if (pick < 75) begin
        send_line(OP_BYTE, CH_CAN, 1);
        send_line(OP_BYTE, 8'($urandom), 1);
      end else begin
        send_line(OP_BYTE, $urandom_range(1) ? CH_SOH : CH_STX, 1);
        repeat ($urandom_range(1, 6)) send_line(OP_BYTE, 8'($urandom), 1);
        send_line(OP_TIMEOUT, 8'($urandom), 1);
      end
    end
    wait_drained();
  endtask

  task automatic test_random();
    gaps_on = 1;
    random_traffic(30);
  endtask

  task automatic test_steady_stream();
    gaps_on = 0;
    random_traffic(15);
  endtask

  task automatic test_session_abort();
    send_line(OP_TIMEOUT, 8'h00);
    send_line(OP_BYTE, CH_UA);
    send_line(OP_TIMEOUT, 8'h00);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tuser <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= 3'd0;
    cfg_pwdata <= 32'd0;
    rx = '{phase: RX_IDLE, mode: SZ_NAME, default: 0};
    max_err_cfg = 8'd5;
    mismatches = 0;
    items_in = 0;
    results_seen = 0;
    hold_req = 0;
    gaps_on = 1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_line_events();
    test_header_and_data();
    test_output_backpressure();
    test_random();
    test_steady_stream();
    test_session_abort();
    $display("Covered line errors, a header with a size field, a stalled data commit and abort.");
    $display("%0d input transactions sent, %0d results checked.", items_in, results_seen);
    if (mismatches == 0 && expected_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    out_tready <= 1'b0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_req > 0) begin
        out_tready <= 1'b0;
        hold_req--;
      end else if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall--;
      end else if (gaps_on && $urandom_range(4) == 0) begin
        out_tready <= 1'b0;
        out_stall = $urandom_range(0, 3);
      end else out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rx_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result kind", out_tuser, 0);
      end else begin
        want = expected_q.pop_front();
        if (out_tuser != want.kind) report_mismatch("kind", out_tuser, want.kind);
        if (out_tdata[7:0] != want.value) report_mismatch("value", out_tdata[7:0], want.value);
        if (out_tdata[39:8] != want.offset)
          report_mismatch("offset", out_tdata[39:8], want.offset);
        if (out_tdata[42:40] != want.status)
          report_mismatch("status", out_tdata[42:40], want.status);
        if (out_tlast != want.last) report_mismatch("last", out_tlast, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule
